[hdl/lpfr_pkg.sv]
// Shared types and constants for the length-prefixed frame receiver.
// No dependencies; imported by every module of the block.
package lpfr_pkg;

  // Widths of the stream and of the session fields.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 31;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Default depth of the result queue.
  localparam int unsigned RESULT_DEPTH_DEFAULT = 4;

  // Largest frame length accepted after reset.
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(65536);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACK        = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_MISMATCH   = 2'd2
  } status_t;

  // One result item as it travels through the queue.
  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  ack_length;
    logic              session_done;
  } result_t;

endpackage

[hdl/lpfr_parser.sv]
// Front part of the receiver: takes one stream byte per transaction and
// produces at most one result per byte. Depends on lpfr_pkg.
module lpfr_parser
  import lpfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_take,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              new_session,
  input  logic              cfg_write,
  input  logic [LEN_W-1:0]  cfg_max_len,
  output logic              res_valid,
  output result_t           res
);

  typedef enum logic [4:0] {
    PH_COUNT   = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_FIELD   = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_STOP    = 5'b10000
  } phase_t;

  phase_t                  phase, phase_next;
  logic [1:0]              field_byte_index;
  logic [FIELD_W-BYTE_W-1:0] field_shift;
  logic [LEN_W-1:0]        frames_declared, frames_declared_next;
  logic [LEN_W-1:0]        frame_length, frame_length_next;
  logic [LEN_W-1:0]        frames_seen, frames_seen_next;
  logic [LEN_W-1:0]        payload_left, payload_left_next;
  logic [LEN_W-1:0]        max_len;

  logic [FIELD_W-1:0]      field_value;
  logic                    field_last;
  logic [LEN_W-1:0]        seen_inc;
  logic [LEN_W-1:0]        left_dec;

  // The 32-bit field as it stands once this byte is shifted in.
  assign field_value = {field_shift, data_byte};
  assign field_last  = (field_byte_index == 2'd3);
  assign seen_inc    = frames_seen + LEN_W'(1);
  assign left_dec    = (payload_left != '0) ? payload_left - LEN_W'(1) : payload_left;

  // Configuration register; it takes effect on the next header.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_len <= cfg_max_len;
    end
  end

  // Phase decisions and the result of this byte.
  always_comb begin
    phase_next           = phase;
    frames_declared_next = frames_declared;
    frame_length_next    = frame_length;
    frames_seen_next     = frames_seen;
    payload_left_next    = payload_left;
    res_valid            = 1'b0;
    res.status           = STATUS_ACK;
    res.ack_length       = '0;
    res.session_done     = 1'b0;
    case (phase)
      PH_COUNT: begin
        if (field_last) begin
          frames_declared_next = field_value[FIELD_W-1] ? '0 : field_value[LEN_W-1:0];
          phase_next           = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (field_last) begin
          if (frames_declared == '0 || field_value[FIELD_W-1] || field_value == '0 ||
              field_value[LEN_W-1:0] > max_len) begin
            phase_next = PH_STOP;
            res_valid  = 1'b1;
            res.status = STATUS_BAD_HEADER;
          end else begin
            frame_length_next = field_value[LEN_W-1:0];
            phase_next        = PH_FIELD;
          end
        end
      end
      PH_FIELD: begin
        if (field_last) begin
          if (field_value != {1'b0, frame_length}) begin
            phase_next = PH_STOP;
            res_valid  = 1'b1;
            res.status = STATUS_MISMATCH;
          end else begin
            payload_left_next = frame_length;
            phase_next        = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = left_dec;
        if (left_dec == '0) begin
          frames_seen_next = seen_inc;
          res_valid        = 1'b1;
          res.ack_length   = frame_length;
          if (seen_inc >= frames_declared) begin
            res.session_done = 1'b1;
            phase_next       = PH_STOP;
          end else begin
            phase_next = PH_FIELD;
          end
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
    // A restart byte gives no result.
    if (new_session) begin
      res_valid = 1'b0;
    end
  end

  // Session state, updated once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_COUNT;
      field_byte_index <= '0;
      field_shift      <= '0;
      frames_declared  <= '0;
      frame_length     <= '0;
      frames_seen      <= '0;
      payload_left     <= '0;
    end else if (in_take) begin
      if (new_session) begin
        phase            <= PH_COUNT;
        field_byte_index <= '0;
        field_shift      <= '0;
        frames_declared  <= '0;
        frame_length     <= '0;
        frames_seen      <= '0;
        payload_left     <= '0;
      end else begin
        // Only the field phases shift bytes in.
        if (phase == PH_COUNT || phase == PH_LENGTH || phase == PH_FIELD) begin
          field_shift      <= field_value[FIELD_W-BYTE_W-1:0];
          field_byte_index <= field_byte_index + 2'd1;
        end
        phase           <= phase_next;
        frames_declared <= frames_declared_next;
        frame_length    <= frame_length_next;
        frames_seen     <= frames_seen_next;
        payload_left    <= payload_left_next;
      end
    end
  end

endmodule

[hdl/lpfr_fifo.sv]
// Result queue between the parser and the result port: a small register
// array with read and write pointers. Depends on lpfr_pkg.
module lpfr_fifo
  import lpfr_pkg::*;
#(
  parameter int unsigned DEPTH = RESULT_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  result_t          slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[hdl/length_prefixed_frame_receiver.sv]
// Length-prefixed frame receiver: takes one stream byte per clock cycle at full
// rate, with no wait states of its own. The parser decides each byte in the cycle
// it is accepted, and its result (acknowledge, bad header or length mismatch) is
// registered at the tail of the result queue. Results wait in a queue of
// FIFO_DEPTH entries; full rises only when that many results are still unread, so
// input stalls come from the result side alone. The max_frame_length register is
// always ready and applies to the next header that completes.
// Depends on lpfr_pkg, lpfr_parser and lpfr_fifo.
module length_prefixed_frame_receiver
  import lpfr_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = RESULT_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // Byte stream.
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              new_session,
  // Results.
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status,
  output logic [LEN_W-1:0]  ack_length,
  output logic              session_done,
  // Configuration.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  max_frame_length
);

  logic    take;
  logic    res_valid;
  result_t res;
  result_t head;

  assign cfg_ready = 1'b1;
  assign take      = push && !full;

  // Front part: byte parsing and session checks.
  lpfr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_take     (take),
    .data_byte   (data_byte),
    .new_session (new_session),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_max_len (max_frame_length),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Back part: queue of results waiting to be popped.
  lpfr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take && res_valid),
    .wr_data (res),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  assign status       = head.status;
  assign ack_length   = head.ack_length;
  assign session_done = head.session_done;

endmodule

[tb/sv/tb_length_prefixed_frame_receiver.sv]
// Self-checking testbench for the length-prefixed frame receiver: stream bytes go in
// through a queue-style port, results are checked against an in-bench parser model.
// Depends on lpfr_pkg and length_prefixed_frame_receiver.
`timescale 1ns / 100ps

module tb_length_prefixed_frame_receiver;
  import lpfr_pkg::*;

  // Parser phases as the bench tracks them.
  typedef enum logic [2:0] {
    P_COUNT   = 3'd0,
    P_LENGTH  = 3'd1,
    P_FIELD   = 3'd2,
    P_PAYLOAD = 3'd3,
    P_STOPPED = 3'd4
  } parse_phase_t;

  // One byte of the stream with its restart flag.
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              restart;
  } stream_item_t;

  localparam int unsigned IDLE_PCT    = 27;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned TOTAL_ITEMS = 1100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              new_session = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [1:0]        status;
  logic [LEN_W-1:0]  ack_length;
  logic              session_done;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  max_frame_length = '0;

  // Bytes waiting to be offered, and the results the parser model predicts.
  stream_item_t stream_backlog[$];
  result_t      awaited_replies[$];

  // Parser model state.
  parse_phase_t     rx_phase = P_COUNT;
  logic [1:0]       byte_count = '0;
  logic [31:0]      field_word = '0;
  logic [LEN_W-1:0] frames_declared = '0;
  logic [LEN_W-1:0] hdr_length = '0;
  logic [LEN_W-1:0] frames_acked = '0;
  logic [LEN_W-1:0] bytes_left = '0;
  logic [LEN_W-1:0] max_len_model = MAX_LEN_RESET;

  // Stimulus-side copy of the limit, used to shape headers.
  logic [LEN_W-1:0] cfg_now = MAX_LEN_RESET;

  int unsigned items_queued = 0;
  int unsigned tx_cycle = 0;
  int unsigned rx_cycle = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int unsigned error_count = 0;

  length_prefixed_frame_receiver u_top (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .data_byte        (data_byte),
    .new_session      (new_session),
    .empty            (empty),
    .pop              (pop),
    .status           (status),
    .ack_length       (ack_length),
    .session_done     (session_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .max_frame_length (max_frame_length)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model: updates its state for one accepted byte and queues any result.
  function automatic void parse_stream_byte(input stream_item_t item);
    logic word_ready;
    if (item.restart) begin
      rx_phase = P_COUNT;
      byte_count = '0;
      field_word = '0;
      frames_declared = '0;
      hdr_length = '0;
      frames_acked = '0;
      bytes_left = '0;
      return;
    end
    if (rx_phase == P_COUNT || rx_phase == P_LENGTH || rx_phase == P_FIELD) begin
      field_word = {field_word[23:0], item.data};
      byte_count = byte_count + 2'd1;
    end
    word_ready = (byte_count == 2'd0);
    case (rx_phase)
      P_COUNT: begin
        if (word_ready) begin
          // A count that is not positive is held as zero.
          frames_declared = field_word[31] ? '0 : field_word[LEN_W-1:0];
          rx_phase = P_LENGTH;
        end
      end
      P_LENGTH: begin
        if (word_ready) begin
          if (frames_declared == '0 || field_word[31] || field_word == '0 ||
              field_word > {1'b0, max_len_model}) begin
            rx_phase = P_STOPPED;
            awaited_replies.insert(awaited_replies.size(),
                                   result_t'{status: STATUS_BAD_HEADER, ack_length: '0,
                                             session_done: 1'b0});
          end else begin
            hdr_length = field_word[LEN_W-1:0];
            rx_phase = P_FIELD;
          end
        end
      end
      P_FIELD: begin
        // A wrong length field is reported on its last byte.
        if (word_ready) begin
          if (field_word != {1'b0, hdr_length}) begin
            rx_phase = P_STOPPED;
            awaited_replies.insert(awaited_replies.size(),
                                   result_t'{status: STATUS_MISMATCH, ack_length: '0,
                                             session_done: 1'b0});
          end else begin
            bytes_left = hdr_length;
            rx_phase = P_PAYLOAD;
          end
        end
      end
      P_PAYLOAD: begin
        if (bytes_left != '0) bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          frames_acked = frames_acked + 1'b1;
          rx_phase = (frames_acked >= frames_declared) ? P_STOPPED : P_FIELD;
          awaited_replies.insert(awaited_replies.size(),
                                 result_t'{status: STATUS_ACK, ack_length: hdr_length,
                                           session_done: frames_acked >= frames_declared});
        end
      end
      default: begin
        // Stopped: bytes are ignored until a restart.
      end
    endcase
  endfunction

  // Sender: offers the oldest backlog byte; keeps it steady while the block is full.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      tx_cycle++;
      if (push && !full) begin
        parse_stream_byte(stream_backlog[0]);
        void'(stream_backlog.pop_front());
      end
      if (stream_backlog.size() != 0 &&
          ((push && full) || (tx_cycle >= 2000 && tx_cycle < 3500) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        push <= 1'b1;
        data_byte <= stream_backlog[0].data;
        new_session <= stream_backlog[0].restart;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: checks each result transaction and pops at random, with one long hold.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      rx_cycle++;
      if (pop && !empty) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected result: status %0d, ack_length %0d, session_done %0d",
                 status, ack_length, session_done);
          error_count++;
        end else begin
          if (status != awaited_replies[0].status) begin
            $error("status: expected %0d, got %0d", awaited_replies[0].status, status);
            error_count++;
          end
          if (ack_length != awaited_replies[0].ack_length) begin
            $error("ack_length: expected %0d, got %0d",
                   awaited_replies[0].ack_length, ack_length);
            error_count++;
          end
          if (session_done != awaited_replies[0].session_done) begin
            $error("session_done: expected %0d, got %0d",
                   awaited_replies[0].session_done, session_done);
            error_count++;
          end
          void'(awaited_replies.pop_front());
        end
        results_seen++;
        // Stop reading for a while so the result queue fills and stalls the input.
        if (results_seen == 50) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (rx_cycle >= 2500 && rx_cycle < 4000) || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  task automatic add_byte(input logic [BYTE_W-1:0] b, input logic rs, input bit counted);
    stream_backlog.insert(stream_backlog.size(), stream_item_t'{data: b, restart: rs});
    if (counted) items_queued++;
  endtask

  task automatic add_noise(input int unsigned n);
    repeat (n) add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  task automatic add_restart();
    add_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  // Big-endian 32-bit field.
  task automatic add_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8], 1'b0, 1'b1);
  endtask

  task automatic add_header(input logic [31:0] frames, input logic [31:0] len);
    add_word(frames);
    add_word(len);
  endtask

  task automatic add_frame(input logic [31:0] field, input int unsigned payload_bytes);
    add_word(field);
    repeat (payload_bytes) add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Waits until every byte is in and every result out, then lets the block settle.
  task automatic wait_until_idle();
    while (stream_backlog.size() != 0 || push || awaited_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write transaction; only issued while the block is idle.
  task automatic write_max_len(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    max_frame_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_len_model = v;
    cfg_now = v;
  endtask

  // One random session: mostly well formed, some bad headers, mismatches and cut-offs.
  task automatic add_random_session();
    logic [31:0] frames;
    logic [31:0] len;
    int unsigned roll;
    int unsigned nframes;
    bit header_ok;
    add_restart();
    if ($urandom_range(0, 99) < 4) begin
      repeat ($urandom_range(1, 7)) add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    roll = $urandom_range(0, 99);
    if (roll < 80) frames = $urandom_range(1, 4);
    else if (roll < 84) frames = '0;
    else if (roll < 88) frames = {1'b1, 31'($urandom)};
    else frames = {1'b0, 31'($urandom)};
    roll = $urandom_range(0, 99);
    if (roll < 78) len = $urandom_range(1, (cfg_now < 12) ? cfg_now : 12);
    else if (roll < 84) len = {1'b0, cfg_now};
    else if (roll < 89) len = {1'b0, cfg_now} + 32'd1;
    else if (roll < 93) len = '0;
    else if (roll < 97) len = {1'b1, 31'($urandom)};
    else len = $urandom;
    add_header(frames, len);
    header_ok = frames != '0 && !frames[31] && len != '0 && !len[31] &&
                len <= {1'b0, cfg_now};
    if (!header_ok) begin
      add_noise($urandom_range(0, 3));
      return;
    end
    nframes = (frames > 6) ? 6 : frames;
    for (int f = 0; f < nframes; f++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        add_word(len ^ (32'd1 << $urandom_range(0, 31)));
        add_noise($urandom_range(0, 3));
        return;
      end
      add_word(len);
      // Long frames and a few short ones are cut off by the next session.
      if (len > 64 || roll < 13) begin
        repeat ($urandom_range(0, (len > 64) ? 64 : len - 1))
          add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        return;
      end
      repeat (len) add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    if (frames <= 6) add_noise($urandom_range(0, 3));
  endtask

  // Stimulus: directed sessions under several limits, then random segments.
  initial begin
    logic [LEN_W-1:0] seg_max [6];
    int unsigned seg_goal;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limit: good sessions, ignored bytes after the end, and each bad header.
    add_header(32'd1, 32'd1);
    add_frame(32'd1, 1);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_restart();
    add_header(32'd2, 32'd3);
    add_frame(32'd3, 3);
    add_frame(32'd3, 3);
    add_restart();
    add_header(32'd0, 32'd4);
    add_restart();
    add_header(32'hFFFF_FFFF, 32'd4);
    add_restart();
    add_header(32'd1, 32'd0);
    add_restart();
    add_header(32'd1, 32'h8000_0000);
    add_restart();
    add_header(32'd1, 32'd65537);
    // Largest accepted length, then a length field that disagrees with it.
    add_restart();
    add_header(32'h7FFF_FFFF, 32'd65536);
    add_word(32'd65535);
    // Mismatch is flagged before any payload of the second frame.
    add_restart();
    add_header(32'h7FFF_FFFF, 32'd2);
    add_frame(32'd2, 2);
    add_word(32'h0000_0102);
    // Restart in the middle of a header field.
    add_restart();
    add_byte(8'h00, 1'b0, 1'b1);
    add_byte(8'hFF, 1'b0, 1'b1);
    add_restart();
    add_header(32'd1, 32'd1);
    add_frame(32'd1, 1);
    wait_until_idle();

    // A zero limit rejects every header.
    write_max_len('0);
    add_restart();
    add_header(32'd1, 32'd1);
    wait_until_idle();

    // Smallest useful limit.
    write_max_len(31'd1);
    add_restart();
    add_header(32'd1, 32'd1);
    add_frame(32'd1, 1);
    add_restart();
    add_header(32'd1, 32'd2);
    wait_until_idle();

    // Largest limit: a full-size frame is accepted, then abandoned by a restart.
    write_max_len(31'h7FFF_FFFF);
    add_restart();
    add_header(32'd2, 32'h7FFF_FFFF);
    add_frame(32'h7FFF_FFFF, 5);
    add_restart();
    add_header(32'd1, 32'h8000_0000);
    wait_until_idle();

    // Random segments, one limit each; they share what is left of the item budget.
    seg_max[0] = 31'd24;
    seg_max[1] = 31'd5;
    seg_max[2] = 31'h7FFF_FFFF;
    seg_max[3] = LEN_W'($urandom_range(1, 40));
    seg_max[4] = MAX_LEN_RESET;
    seg_max[5] = 31'd1;
    for (int s = 0; s < 6; s++) begin
      write_max_len(seg_max[s]);
      seg_goal = items_queued +
                 ((items_queued < TOTAL_ITEMS) ? (TOTAL_ITEMS - items_queued) / (6 - s) : 0);
      while (items_queued < seg_goal) add_random_session();
      wait_until_idle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
